[hdl/bxhs_pkg.sv]
// shared types, constants and helpers of the bond transmit hash selector
package bxhs_pkg;

    localparam int MAX_RINGS      = 10;
    localparam int RING_W         = 4;
    localparam int WORD_W         = 32;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = WORD_W / DIV_STAGES;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int POLICY_W       = 3;

    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    localparam logic [POLICY_W-1:0] POL_L2  = 3'd0;
    localparam logic [POLICY_W-1:0] POL_L34 = 3'd1;
    localparam logic [POLICY_W-1:0] POL_L23 = 3'd2;
    localparam logic [POLICY_W-1:0] POL_E23 = 3'd3;
    localparam logic [POLICY_W-1:0] POL_E34 = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LACP_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_POLICY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT  = 2'd2;

    localparam logic [RING_W-1:0] MAX_RINGS_CODE = RING_W'(MAX_RINGS);

    typedef struct packed {
        logic                lacp;
        logic [POLICY_W-1:0] policy;
        logic [RING_W-1:0]   count;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic [RING_W-1:0] rem;
        logic [WORD_W-1:0] word;
    } div_word_t;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

    function automatic logic [WORD_W-1:0] fold(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t    = w ^ (w >> 16);
        fold = t ^ (t >> 8);
    endfunction

endpackage

[hdl/bxhs_hash.sv]
// header field selection and folding into the hash word, two register stages
module bxhs_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  bxhs_pkg::cfg_t            cfg,
    input  logic [7:0]                src_mac_last,
    input  logic [7:0]                dst_mac_last,
    input  logic [15:0]               ether_type,
    input  logic [15:0]               inner_ether_type,
    input  logic [31:0]               source_ip,
    input  logic [31:0]               dest_ip,
    input  logic [15:0]               source_port,
    input  logic [15:0]               dest_port,
    output bxhs_pkg::div_word_t       out_word
);
    import bxhs_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_zero_reg, s1_zero_next;
    logic              s1_fold_reg, s1_fold_next;
    logic [WORD_W-1:0] s1_word_reg, s1_word_next;

    logic              s2_valid_reg;
    logic              s2_zero_reg, s2_zero_next;
    logic [WORD_W-1:0] s2_word_reg, s2_word_next;

    always_comb
    begin
        logic [15:0]       etype;
        logic [WORD_W-1:0] mac_mix;
        logic [WORD_W-1:0] ip_mix;
        etype = ether_type;
        if (cfg.policy > POL_L23 && ether_type == ETYPE_VLAN)
        begin
            etype = inner_ether_type;
        end
        mac_mix = {16'd0, swap16(etype) ^ {8'd0, dst_mac_last ^ src_mac_last}};
        ip_mix  = dest_ip ^ source_ip;

        s1_valid_next = in_valid;
        s1_zero_next  = !cfg.lacp || cfg.count == '0;
        s1_fold_next  = 1'b0;
        s1_word_next  = mac_mix;
        priority if (etype != ETYPE_IPV4 || cfg.policy == POL_L2)
        begin
            s1_word_next = mac_mix;
        end
        else if (cfg.policy == POL_L23 || cfg.policy == POL_E23)
        begin
            s1_fold_next = 1'b1;
            s1_word_next = mac_mix ^ ip_mix;
        end
        else if (cfg.policy == POL_L34 || cfg.policy == POL_E34)
        begin
            s1_fold_next = 1'b1;
            s1_word_next = {dest_port, source_port} ^ ip_mix;
        end
        else
        begin
            // unknown policy on an ipv4 frame
            s1_zero_next = 1'b1;
        end
    end

    always_comb
    begin
        s2_zero_next = s1_zero_reg;
        s2_word_next = s1_fold_reg ? fold(s1_word_reg) : s1_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_zero_reg <= s1_zero_next;
        s1_fold_reg <= s1_fold_next;
        s1_word_reg <= s1_word_next;
        s2_zero_reg <= s2_zero_next;
        s2_word_reg <= s2_word_next;
    end

    assign out_word.valid = s2_valid_reg;
    assign out_word.zero  = s2_zero_reg;
    assign out_word.rem   = '0;
    assign out_word.word  = s2_word_reg;

endmodule

[hdl/bxhs_div_stage.sv]
// one stage of the restoring remainder, a slice of hash word bits per stage
module bxhs_div_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bxhs_pkg::RING_W-1:0]  count,
    input  bxhs_pkg::div_word_t          in_word,
    output bxhs_pkg::div_word_t          out_word
);
    import bxhs_pkg::*;

    logic              valid_reg;
    logic              zero_reg;
    logic [RING_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] word_reg, word_next;

    always_comb
    begin
        logic [RING_W:0]   r;
        logic [WORD_W-1:0] w;
        r = {1'b0, in_word.rem};
        w = in_word.word;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            r = {r[RING_W-1:0], w[WORD_W-1]};
            w = w << 1;
            if (r >= {1'b0, count})
            begin
                r = r - {1'b0, count};
            end
        end
        // forced results carry a zero remainder
        rem_next  = in_word.zero ? '0 : r[RING_W-1:0];
        word_next = w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_word.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= in_word.zero;
        rem_reg  <= rem_next;
        word_reg <= word_next;
    end

    assign out_word.valid = valid_reg;
    assign out_word.zero  = zero_reg;
    assign out_word.rem   = rem_reg;
    assign out_word.word  = word_reg;

endmodule

[hdl/bond_xmit_hash_select.sv]
// link-aggregation transmit hash: member ring selection, top level
// done follows an accepted start through the field select, fold and remainder stage registers
// throughput: one word per cycle; busy is always low, the pipeline never stalls
// stages: field select, fold, then four 8-bit steps of the ring-count remainder
// reset clears the pipeline valid bits; lacp_mode 0, hash_policy 0, ring_count 1
module bond_xmit_hash_select (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [bxhs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bxhs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [7:0]                        src_mac_last,
    input  logic [7:0]                        dst_mac_last,
    input  logic [15:0]                       ether_type,
    input  logic [15:0]                       inner_ether_type,
    input  logic [31:0]                       source_ip,
    input  logic [31:0]                       dest_ip,
    input  logic [15:0]                       source_port,
    input  logic [15:0]                       dest_port,
    output logic                              done,
    output logic [bxhs_pkg::RING_W-1:0]       ring_index
);
    import bxhs_pkg::*;

    logic                lacp_mode_reg;
    logic [POLICY_W-1:0] hash_policy_reg;
    logic [RING_W-1:0]   ring_count_reg;
    cfg_t                cfg;
    div_word_t           stage_word [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lacp_mode_reg   <= 1'b0;
            hash_policy_reg <= POL_L2;
            ring_count_reg  <= RING_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LACP_MODE:   lacp_mode_reg   <= cfg_data[0];
                REG_HASH_POLICY: hash_policy_reg <= cfg_data[POLICY_W-1:0];
                REG_RING_COUNT:  ring_count_reg  <= cfg_data[RING_W-1:0];
                default:         ;
            endcase
        end
    end

    // ring count saturates at the largest bond
    assign cfg.lacp   = lacp_mode_reg;
    assign cfg.policy = hash_policy_reg;
    assign cfg.count  = (ring_count_reg > MAX_RINGS_CODE) ? MAX_RINGS_CODE : ring_count_reg;

    assign busy = 1'b0;

    bxhs_hash u_hash (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (start && !busy),
        .cfg              (cfg),
        .src_mac_last     (src_mac_last),
        .dst_mac_last     (dst_mac_last),
        .ether_type       (ether_type),
        .inner_ether_type (inner_ether_type),
        .source_ip        (source_ip),
        .dest_ip          (dest_ip),
        .source_port      (source_port),
        .dest_port        (dest_port),
        .out_word         (stage_word[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        bxhs_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .count    (cfg.count),
            .in_word  (stage_word[g]),
            .out_word (stage_word[g+1])
        );
    end

    assign done       = stage_word[DIV_STAGES].valid;
    assign ring_index = stage_word[DIV_STAGES].rem;

endmodule

[tb/bxhs_checker.sv]
// checker of the bond transmit hash selector: predicts each ring index and compares
`timescale 1ns / 1ps

module bxhs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            cfg_we,
    input  logic [bxhs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bxhs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]                      src_mac_last,
    input  logic [7:0]                      dst_mac_last,
    input  logic [15:0]                     ether_type,
    input  logic [15:0]                     inner_ether_type,
    input  logic [31:0]                     source_ip,
    input  logic [31:0]                     dest_ip,
    input  logic [15:0]                     source_port,
    input  logic [15:0]                     dest_port,
    input  logic                            done,
    input  logic [bxhs_pkg::RING_W-1:0]     ring_index,
    output int                              errors,
    output int                              pending
);
    import bxhs_pkg::*;

    typedef struct packed {
        logic [7:0]  smac;
        logic [7:0]  dmac;
        logic [15:0] etype;
        logic [15:0] inner;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
    } header_t;

    // shadow of the bond registers
    logic                bond_lacp;
    logic [POLICY_W-1:0] bond_policy;
    logic [RING_W-1:0]   bond_count;

    logic [RING_W-1:0] expected_rings[$];

    function automatic logic [RING_W-1:0] predict_ring(input header_t h,
                                                       input logic lacp,
                                                       input logic [POLICY_W-1:0] pol,
                                                       input logic [RING_W-1:0] cnt);
        logic [RING_W-1:0] rings;
        logic [15:0]       et;
        logic [15:0]       swapped;
        logic [31:0]       mac_mix;
        logic [31:0]       w;
        rings = (cnt > MAX_RINGS_CODE) ? MAX_RINGS_CODE : cnt;
        if (!lacp || rings == '0)
            return '0;
        et = h.etype;
        // encapsulation and unknown policies look behind a vlan tag
        if (pol > POL_L23 && et == ETYPE_VLAN)
            et = h.inner;
        swapped = {et[7:0], et[15:8]};
        mac_mix = {24'h0, h.dmac ^ h.smac} ^ {16'h0, swapped};
        if (et != ETYPE_IPV4 || pol == POL_L2)
            w = mac_mix;
        else if (pol == POL_L23 || pol == POL_E23)
            w = mac_mix ^ h.dip ^ h.sip;
        else if (pol == POL_L34 || pol == POL_E34)
            w = {h.dport, h.sport} ^ h.dip ^ h.sip;
        else
            return '0;
        if (!(et != ETYPE_IPV4 || pol == POL_L2))
        begin
            w = w ^ (w >> 16);
            w = w ^ (w >> 8);
        end
        return RING_W'(w % {28'h0, rings});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [RING_W-1:0] want;
        if (!rst_n)
        begin
            bond_lacp   = 1'b0;
            bond_policy = POL_L2;
            bond_count  = RING_W'(1);
            expected_rings.delete();
            errors      = 0;
            pending    <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_rings.size() == 0)
                begin
                    $display("%0t unexpected ring_index word: expected none, actual %0d",
                             $time, ring_index);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_rings.pop_front();
                    if (ring_index !== want)
                    begin
                        $display("%0t ring_index mismatch: expected %0d, actual %0d",
                                 $time, want, ring_index);
                        errors = errors + 1;
                    end
                end
            end
            if (start && !busy)
                expected_rings.insert(expected_rings.size(),
                                      predict_ring({src_mac_last, dst_mac_last, ether_type,
                                                    inner_ether_type, source_ip, dest_ip,
                                                    source_port, dest_port},
                                                   bond_lacp, bond_policy, bond_count));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LACP_MODE:   bond_lacp   = cfg_data[0];
                    REG_HASH_POLICY: bond_policy = cfg_data[POLICY_W-1:0];
                    REG_RING_COUNT:  bond_count  = cfg_data[RING_W-1:0];
                    default:         ;
                endcase
            end
            pending <= expected_rings.size();
        end
    end

endmodule

[tb/tb_bond_xmit_hash_select.sv]
// testbench top of the bond transmit hash selector: stimulus, register setup and verdict
`timescale 1ns / 1ps

module tb_bond_xmit_hash_select;
    import bxhs_pkg::*;

    localparam int                   LATENCY      = 6;
    localparam int                   PHASES       = 14;
    localparam int                   PHASE_ITEMS  = 125;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
    localparam logic [POLICY_W-1:0]  POL_UNKNOWN  = 3'd7;
    localparam logic [15:0]          ETYPE_IPV6   = 16'h86dd;

    logic                  clk;
    logic                  rst_n            = 1'b0;
    logic                  start            = 1'b0;
    logic                  busy;
    logic                  cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index        = '0;
    logic [CFG_DATA_W-1:0] cfg_data         = '0;
    logic [7:0]            src_mac_last     = '0;
    logic [7:0]            dst_mac_last     = '0;
    logic [15:0]           ether_type       = '0;
    logic [15:0]           inner_ether_type = '0;
    logic [31:0]           source_ip        = '0;
    logic [31:0]           dest_ip          = '0;
    logic [15:0]           source_port      = '0;
    logic [15:0]           dest_port        = '0;
    logic                  done;
    logic [RING_W-1:0]     ring_index;

    int errors;
    int pending;
    bit sender_idles = 1'b1;

    bond_xmit_hash_select i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .src_mac_last     (src_mac_last),
        .dst_mac_last     (dst_mac_last),
        .ether_type       (ether_type),
        .inner_ether_type (inner_ether_type),
        .source_ip        (source_ip),
        .dest_ip          (dest_ip),
        .source_port      (source_port),
        .dest_port        (dest_port),
        .done             (done),
        .ring_index       (ring_index)
    );

    bxhs_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .src_mac_last     (src_mac_last),
        .dst_mac_last     (dst_mac_last),
        .ether_type       (ether_type),
        .inner_ether_type (inner_ether_type),
        .source_ip        (source_ip),
        .dest_ip          (dest_ip),
        .source_port      (source_port),
        .dest_port        (dest_port),
        .done             (done),
        .ring_index       (ring_index),
        .errors           (errors),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_header(input logic [7:0] smac, input logic [7:0] dmac,
                               input logic [15:0] etype, input logic [15:0] inner,
                               input logic [31:0] sip, input logic [31:0] dip,
                               input logic [15:0] sport, input logic [15:0] dport);
        int gap;
        gap = sender_idles ? $urandom_range(0, 3) : 0;
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        src_mac_last     <= smac;
        dst_mac_last     <= dmac;
        ether_type       <= etype;
        inner_ether_type <= inner;
        source_ip        <= sip;
        dest_ip          <= dip;
        source_port      <= sport;
        dest_port        <= dport;
        start            <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every word is back, then let the pipeline run dry
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 2)
            @(posedge clk);
    endtask

    task automatic program_bond(input logic lacp, input logic [POLICY_W-1:0] pol,
                                input logic [RING_W-1:0] cnt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LACP_MODE;
        cfg_data  <= {3'($urandom), lacp};
        @(posedge clk);
        cfg_index <= REG_HASH_POLICY;
        cfg_data  <= {1'($urandom), pol};
        @(posedge clk);
        cfg_index <= REG_RING_COUNT;
        cfg_data  <= cnt;
        @(posedge clk);
        if ($urandom_range(0, 1) == 0)
        begin
            // unmapped index must leave the bond setup alone
            cfg_index <= REG_UNUSED;
            cfg_data  <= 4'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_header();
        logic [15:0] etype;
        logic [15:0] inner;
        int          kind;
        kind  = $urandom_range(0, 7);
        inner = 16'($urandom);
        if (kind <= 3)
            etype = ETYPE_IPV4;
        else if (kind <= 5)
        begin
            etype = ETYPE_VLAN;
            if ($urandom_range(0, 2) != 0)
                inner = ETYPE_IPV4;
        end
        else if (kind == 6)
            etype = 16'($urandom);
        else
        begin
            // one bit off a recognized ethertype
            etype = ($urandom_range(0, 1) ? ETYPE_IPV4 : ETYPE_VLAN)
                    ^ (16'h1 << $urandom_range(0, 15));
            if ($urandom_range(0, 1) == 0)
                inner = ETYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15));
        end
        send_header(8'($urandom), 8'($urandom), etype, inner,
                    $urandom, $urandom, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        logic              lacp;
        logic [RING_W-1:0] cnt;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setup: not an 802.3ad bond
        send_header(8'hff, 8'hff, ETYPE_IPV4, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
                    16'hffff, 16'hffff);
        settle();

        program_bond(1'b1, POL_L2, 4'd10);
        send_header(8'h00, 8'h00, ETYPE_IPV4, 16'h0000, 32'h0, 32'h0, 16'h0, 16'h0);
        send_header(8'hff, 8'h00, ETYPE_IPV4, 16'hffff, 32'h1234_5678, 32'h9abc_def0,
                    16'h0050, 16'h1f90);
        send_header(8'ha5, 8'h5a, ETYPE_IPV6, 16'h0000, 32'hffff_ffff, 32'h0, 16'hffff, 16'h0);
        settle();

        program_bond(1'b1, POL_L23, 4'd7);
        send_header(8'hff, 8'hff, ETYPE_IPV4, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
                    16'hffff, 16'hffff);
        send_header(8'h00, 8'h00, ETYPE_IPV4, 16'h0000, 32'h0, 32'h0, 16'h0, 16'h0);
        // plain policies do not look behind the tag
        send_header(8'h12, 8'h34, ETYPE_VLAN, ETYPE_IPV4, 32'h0a00_0001, 32'h0a00_0002,
                    16'h0001, 16'h0002);
        settle();

        program_bond(1'b1, POL_L34, 4'd3);
        send_header(8'h00, 8'hff, ETYPE_IPV4, 16'h0000, 32'h0100_a8c0, 32'h0200_a8c0,
                    16'hffff, 16'h0000);
        send_header(8'h77, 8'h88, ETYPE_IPV4, 16'h0000, 32'h0, 32'h0, 16'h0000, 16'hffff);
        settle();

        // ring count above the maximum saturates
        program_bond(1'b1, POL_E23, 4'd15);
        send_header(8'h3c, 8'hc3, ETYPE_VLAN, ETYPE_IPV4, 32'hdead_beef, 32'hcafe_f00d,
                    16'h1111, 16'h2222);
        send_header(8'h3c, 8'hc3, ETYPE_VLAN, ETYPE_IPV6, 32'hdead_beef, 32'hcafe_f00d,
                    16'h1111, 16'h2222);
        send_header(8'h01, 8'h02, ETYPE_IPV4, 16'h0000, 32'hffff_ffff, 32'h0,
                    16'h0, 16'h0);
        settle();

        program_bond(1'b1, POL_E34, 4'd9);
        send_header(8'h10, 8'h20, ETYPE_VLAN, ETYPE_IPV4, 32'h0102_0304, 32'h0506_0708,
                    16'hffff, 16'hffff);
        send_header(8'h10, 8'h20, ETYPE_IPV4, 16'hffff, 32'h0102_0304, 32'h0506_0708,
                    16'h0035, 16'hc350);
        send_header(8'hfe, 8'hef, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
                    16'hffff, 16'hffff);
        settle();

        // unknown policy: ipv4 gives ring 0, other frames take the mac hash
        program_bond(1'b1, POL_UNKNOWN, 4'd5);
        send_header(8'h55, 8'haa, ETYPE_IPV4, 16'h0000, 32'h1, 32'h2, 16'h3, 16'h4);
        send_header(8'h55, 8'haa, ETYPE_VLAN, ETYPE_IPV4, 32'h1, 32'h2, 16'h3, 16'h4);
        send_header(8'h55, 8'haa, ETYPE_VLAN, 16'h0806, 32'h1, 32'h2, 16'h3, 16'h4);
        send_header(8'h9d, 8'h0e, 16'h0806, 16'h0000, 32'h1, 32'h2, 16'h3, 16'h4);
        settle();

        // zero ring count
        program_bond(1'b1, POL_L23, 4'd0);
        send_header(8'h9d, 8'h0e, ETYPE_IPV4, 16'h0000, 32'h8765_4321, 32'h1, 16'h3, 16'h4);
        settle();

        program_bond(1'b0, POL_L34, 4'd10);
        send_header(8'h9d, 8'h0e, ETYPE_IPV4, 16'h0000, 32'h8765_4321, 32'h1, 16'h3, 16'h4);
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            lacp = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 4) != 0)
                cnt = RING_W'($urandom_range(1, MAX_RINGS));
            else
                cnt = RING_W'($urandom_range(0, 15));
            program_bond(lacp, POLICY_W'($urandom_range(0, 7)), cnt);
            sender_idles = ($urandom_range(0, 2) != 0);
            repeat (PHASE_ITEMS)
                random_header();
            settle();
        end

        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
